// ===== rtl/tba_pkg.sv =====
// ----------------------------------------------------------------------------
// tba_pkg
// Shared types and constants for the transformed bounds accumulator:
// register indexes, axis count and the control group between the
// transform pipeline and the bounds stage.
// ----------------------------------------------------------------------------
package tba_pkg;

   // Number of coordinate axes
   localparam int NUM_AXES = 3;

   // Register indexes in the configuration map
   localparam int REG_IDX_W  = 3;
   localparam logic [REG_IDX_W-1:0] REG_ROW_X  = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_ROW_Y  = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_ROW_Z  = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_OFFS_X = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_OFFS_Y = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_OFFS_Z = 3'd5;

   // Control travelling with a transformed point
   typedef struct packed {
      logic valid;
      logic restart;
   } pt_ctl_type;

endpackage

// ===== rtl/tba_req_if.sv =====
// ----------------------------------------------------------------------------
// tba_req_if
// Vertex channel: valid/ready handshake carrying one Q16.16 vertex and the
// restart flag per item.
// ----------------------------------------------------------------------------
interface tba_req_if #(
   parameter int COORD_WIDTH = 32
);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] vertex_x;
   logic signed [COORD_WIDTH-1:0] vertex_y;
   logic signed [COORD_WIDTH-1:0] vertex_z;
   logic                          restart;

   modport source (output valid, vertex_x, vertex_y, vertex_z, restart, input ready);
   modport sink   (input valid, vertex_x, vertex_y, vertex_z, restart, output ready);
endinterface

// ===== rtl/tba_rsp_if.sv =====
// ----------------------------------------------------------------------------
// tba_rsp_if
// Bounds channel: valid/ready handshake carrying the running per-axis
// minimum and maximum, one item per accepted vertex.
// ----------------------------------------------------------------------------
interface tba_rsp_if #(
   parameter int COORD_WIDTH = 32
);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] low_x;
   logic signed [COORD_WIDTH-1:0] low_y;
   logic signed [COORD_WIDTH-1:0] low_z;
   logic signed [COORD_WIDTH-1:0] high_x;
   logic signed [COORD_WIDTH-1:0] high_y;
   logic signed [COORD_WIDTH-1:0] high_z;

   modport source (output valid, low_x, low_y, low_z, high_x, high_y, high_z, input ready);
   modport sink   (input valid, low_x, low_y, low_z, high_x, high_y, high_z, output ready);
endinterface

// ===== rtl/tba_csr.sv =====
// ----------------------------------------------------------------------------
// tba_csr
// APB-style register file holding the three transform rows and the three
// translations. Reset loads the identity transform.
// ----------------------------------------------------------------------------
module tba_csr #(
   parameter int COORD_WIDTH = 32,
   parameter int COEFF_WIDTH = 16,
   parameter int CSR_DW      = 64,
   parameter int ADDR_LSB    = 3
) (
   input  logic                                                clock,
   input  logic                                                reset,
   input  logic                                                psel,
   input  logic                                                penable,
   input  logic                                                pwrite,
   input  logic [ADDR_LSB+tba_pkg::REG_IDX_W-1:0]              paddr,
   input  logic [CSR_DW-1:0]                                   pwdata,
   output logic [CSR_DW-1:0]                                   prdata,
   output logic                                                pready,
   output logic [tba_pkg::NUM_AXES-1:0][3*COEFF_WIDTH-1:0]     row_coeffs,
   output logic [tba_pkg::NUM_AXES-1:0][COORD_WIDTH-1:0]       offsets
);
   import tba_pkg::*;

   localparam int ROW_W = 3 * COEFF_WIDTH;
   // Q2.14-style unity in a coefficient slot
   localparam logic [ROW_W-1:0] UNITY = ROW_W'(1) << (COEFF_WIDTH - 2);

   logic [NUM_AXES-1:0][ROW_W-1:0]       row_ff, row_in;
   logic [NUM_AXES-1:0][COORD_WIDTH-1:0] offs_ff, offs_in;
   logic [REG_IDX_W-1:0]                 reg_idx;
   logic                                 wr_en;

   assign reg_idx = paddr[ADDR_LSB +: REG_IDX_W];
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;

   // Register write decode; unknown indexes are dropped
   always_comb begin
      row_in  = row_ff;
      offs_in = offs_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_ROW_X:  row_in[0]  = pwdata[ROW_W-1:0];
            REG_ROW_Y:  row_in[1]  = pwdata[ROW_W-1:0];
            REG_ROW_Z:  row_in[2]  = pwdata[ROW_W-1:0];
            REG_OFFS_X: offs_in[0] = pwdata[COORD_WIDTH-1:0];
            REG_OFFS_Y: offs_in[1] = pwdata[COORD_WIDTH-1:0];
            REG_OFFS_Z: offs_in[2] = pwdata[COORD_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // Identity rows at reset: row r has unity in the slot for axis r
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < NUM_AXES; r++) begin
            row_ff[r]  <= UNITY << ((NUM_AXES - 1 - r) * COEFF_WIDTH);
            offs_ff[r] <= '0;
         end
      end else begin
         row_ff  <= row_in;
         offs_ff <= offs_in;
      end
   end

   // Read-back
   always_comb begin
      unique case (reg_idx)
         REG_ROW_X:  prdata = CSR_DW'(row_ff[0]);
         REG_ROW_Y:  prdata = CSR_DW'(row_ff[1]);
         REG_ROW_Z:  prdata = CSR_DW'(row_ff[2]);
         REG_OFFS_X: prdata = CSR_DW'(offs_ff[0]);
         REG_OFFS_Y: prdata = CSR_DW'(offs_ff[1]);
         REG_OFFS_Z: prdata = CSR_DW'(offs_ff[2]);
         default:    prdata = '0;
      endcase
   end

   assign row_coeffs = row_ff;
   assign offsets    = offs_ff;

endmodule

// ===== rtl/tba_xform.sv =====
// ----------------------------------------------------------------------------
// tba_xform
// Four-stage affine transform pipeline: vertex register, nine products,
// per-axis sum with half-LSB rounding, then shift, offset and saturation.
// Each stage advances when the next one is empty or moving.
// ----------------------------------------------------------------------------
module tba_xform #(
   parameter int COORD_WIDTH = 32,
   parameter int COEFF_WIDTH = 16
) (
   input  logic                                            clock,
   input  logic                                            reset,
   tba_req_if.sink                                         req_bus,
   input  logic [tba_pkg::NUM_AXES-1:0][3*COEFF_WIDTH-1:0] row_coeffs,
   input  logic [tba_pkg::NUM_AXES-1:0][COORD_WIDTH-1:0]   offsets,
   output tba_pkg::pt_ctl_type                             pt_ctl,
   output logic [tba_pkg::NUM_AXES-1:0][COORD_WIDTH-1:0]   pt_coord,
   input  logic                                            pt_ready
);
   import tba_pkg::*;

   localparam int NSTG   = 4;
   localparam int PROD_W = COORD_WIDTH + COEFF_WIDTH;
   localparam int SUM_W  = PROD_W + 2;
   localparam int FRAC   = COEFF_WIDTH - 2;
   localparam int QUO_W  = SUM_W - FRAC;
   localparam int OFS_W  = QUO_W + 1;
   localparam int TOP_W  = OFS_W - COORD_WIDTH + 1;
   localparam logic [SUM_W-1:0]       ROUND_HALF = SUM_W'(1) << (FRAC - 1);
   localparam logic [COORD_WIDTH-1:0] SAT_MAX    = {1'b0, {(COORD_WIDTH-1){1'b1}}};
   localparam logic [COORD_WIDTH-1:0] SAT_MIN    = {1'b1, {(COORD_WIDTH-1){1'b0}}};

   logic [NSTG-1:0] vld_ff, vld_in, rst_ff, rst_in, stg_rdy;

   logic [NUM_AXES-1:0][COORD_WIDTH-1:0]          vert_ff, vert_in;
   logic [NUM_AXES-1:0][NUM_AXES-1:0][PROD_W-1:0] prod_ff, prod_in;
   logic [NUM_AXES-1:0][SUM_W-1:0]                sum_ff, sum_in;
   logic [NUM_AXES-1:0][COORD_WIDTH-1:0]          coord_ff, coord_in;
   logic [NUM_AXES-1:0][QUO_W-1:0]                quo;
   logic [NUM_AXES-1:0][OFS_W-1:0]                moved;
   logic [NUM_AXES-1:0][TOP_W-1:0]                top_bits;

   // Stage advance: a stage takes new data when empty or when it drains
   always_comb begin
      stg_rdy[NSTG-1] = !vld_ff[NSTG-1] || pt_ready;
      for (int k = NSTG - 2; k >= 0; k--) begin
         stg_rdy[k] = !vld_ff[k] || stg_rdy[k+1];
      end
      vld_in[0] = stg_rdy[0] ? req_bus.valid   : vld_ff[0];
      rst_in[0] = stg_rdy[0] ? req_bus.restart : rst_ff[0];
      for (int k = 1; k < NSTG; k++) begin
         vld_in[k] = stg_rdy[k] ? vld_ff[k-1] : vld_ff[k];
         rst_in[k] = stg_rdy[k] ? rst_ff[k-1] : rst_ff[k];
      end
   end

   // Stage 1: vertex register
   always_comb begin
      vert_in = vert_ff;
      if (stg_rdy[0]) begin
         vert_in[0] = req_bus.vertex_x;
         vert_in[1] = req_bus.vertex_y;
         vert_in[2] = req_bus.vertex_z;
      end
   end

   // Stage 2: one product per row and vertex axis
   always_comb begin
      prod_in = prod_ff;
      if (stg_rdy[1]) begin
         for (int r = 0; r < NUM_AXES; r++) begin
            for (int j = 0; j < NUM_AXES; j++) begin
               prod_in[r][j] = PROD_W'($signed(vert_ff[j]) * $signed(
                  row_coeffs[r][(NUM_AXES-1-j)*COEFF_WIDTH +: COEFF_WIDTH]));
            end
         end
      end
   end

   // Stage 3: exact row sum plus half an output LSB
   always_comb begin
      sum_in = sum_ff;
      if (stg_rdy[2]) begin
         for (int r = 0; r < NUM_AXES; r++) begin
            sum_in[r] = SUM_W'($signed(prod_ff[r][0])) + SUM_W'($signed(prod_ff[r][1]))
                      + SUM_W'($signed(prod_ff[r][2])) + ROUND_HALF;
         end
      end
   end

   // Stage 4: floor to Q16.16, add translation, clamp to coordinate range
   always_comb begin
      coord_in = coord_ff;
      for (int r = 0; r < NUM_AXES; r++) begin
         quo[r]      = sum_ff[r][SUM_W-1:FRAC];
         moved[r]    = OFS_W'($signed(quo[r])) + OFS_W'($signed(offsets[r]));
         top_bits[r] = moved[r][OFS_W-1:COORD_WIDTH-1];
         if (stg_rdy[3]) begin
            if ((&top_bits[r]) || !(|top_bits[r])) begin
               coord_in[r] = moved[r][COORD_WIDTH-1:0];
            end else if (moved[r][OFS_W-1]) begin
               coord_in[r] = SAT_MIN;
            end else begin
               coord_in[r] = SAT_MAX;
            end
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      rst_ff   <= rst_in;
      vert_ff  <= vert_in;
      prod_ff  <= prod_in;
      sum_ff   <= sum_in;
      coord_ff <= coord_in;
   end

   assign req_bus.ready  = stg_rdy[0];
   assign pt_ctl.valid   = vld_ff[NSTG-1];
   assign pt_ctl.restart = rst_ff[NSTG-1];
   assign pt_coord       = coord_ff;

endmodule

// ===== rtl/tba_bounds.sv =====
// ----------------------------------------------------------------------------
// tba_bounds
// Running per-axis minimum and maximum. The bounds registers double as the
// result register: they change only when an item moves in.
// ----------------------------------------------------------------------------
module tba_bounds #(
   parameter int COORD_WIDTH = 32
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  tba_pkg::pt_ctl_type                           pt_ctl,
   input  logic [tba_pkg::NUM_AXES-1:0][COORD_WIDTH-1:0] pt_coord,
   output logic                                          pt_ready,
   tba_rsp_if.source                                     rsp_bus
);
   import tba_pkg::*;

   localparam logic [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
   localparam logic [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

   logic                                 out_vld_ff, out_vld_in;
   logic [NUM_AXES-1:0][COORD_WIDTH-1:0] low_ff, low_in, high_ff, high_in;
   logic [NUM_AXES-1:0][COORD_WIDTH-1:0] low_base, high_base;
   logic                                 take;

   assign pt_ready = !out_vld_ff || rsp_bus.ready;
   assign take     = pt_ready && pt_ctl.valid;

   // Restart folds the cleared bounds in ahead of this item's compare
   always_comb begin
      out_vld_in = pt_ready ? pt_ctl.valid : out_vld_ff;
      low_in     = low_ff;
      high_in    = high_ff;
      for (int a = 0; a < NUM_AXES; a++) begin
         low_base[a]  = pt_ctl.restart ? COORD_MAX : low_ff[a];
         high_base[a] = pt_ctl.restart ? COORD_MIN : high_ff[a];
         if (take) begin
            low_in[a]  = ($signed(pt_coord[a]) < $signed(low_base[a]))  ? pt_coord[a]
                                                                        : low_base[a];
            high_in[a] = ($signed(pt_coord[a]) > $signed(high_base[a])) ? pt_coord[a]
                                                                        : high_base[a];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
         for (int a = 0; a < NUM_AXES; a++) begin
            low_ff[a]  <= COORD_MAX;
            high_ff[a] <= COORD_MIN;
         end
      end else begin
         out_vld_ff <= out_vld_in;
         low_ff     <= low_in;
         high_ff    <= high_in;
      end
   end

   assign rsp_bus.valid  = out_vld_ff;
   assign rsp_bus.low_x  = low_ff[0];
   assign rsp_bus.low_y  = low_ff[1];
   assign rsp_bus.low_z  = low_ff[2];
   assign rsp_bus.high_x = high_ff[0];
   assign rsp_bus.high_y = high_ff[1];
   assign rsp_bus.high_z = high_ff[2];

endmodule

// ===== rtl/transformed_bounds_accumulator.sv =====
// ----------------------------------------------------------------------------
// transformed_bounds_accumulator
// Applies a programmable affine transform to each vertex and keeps the
// running axis-aligned bounds of the transformed points.
//
//   channel   direction  handshake           payload
//   req_bus   in         valid/ready         vertex_x/y/z, restart
//   rsp_bus   out        valid/ready         low_x/y/z, high_x/y/z
//   csr       in         psel/penable/pwrite paddr, pwdata, prdata
//
// One vertex per cycle unless a stall backs up to req_bus.ready; an accepted
// vertex passes four transform stages (register, multiply, sum, offset/clamp)
// and the bounds register. Reset loads the identity transform and empties
// the pipeline. With rsp_bus.ready low the result holds and the pipeline
// keeps taking items until all five places are full.
// ----------------------------------------------------------------------------
module transformed_bounds_accumulator #(
   parameter int COORD_WIDTH = 32,
   parameter int COEFF_WIDTH = 16,
   parameter int CSR_DW      = ((3 * COEFF_WIDTH > 32) || (COORD_WIDTH > 32)) ? 64 : 32,
   parameter int ADDR_LSB    = (CSR_DW > 32) ? 3 : 2
) (
   input  logic                                   clock,
   input  logic                                   reset,
   tba_req_if.sink                                req_bus,
   tba_rsp_if.source                              rsp_bus,
   input  logic                                   psel,
   input  logic                                   penable,
   input  logic                                   pwrite,
   input  logic [ADDR_LSB+tba_pkg::REG_IDX_W-1:0] paddr,
   input  logic [CSR_DW-1:0]                      pwdata,
   output logic [CSR_DW-1:0]                      prdata,
   output logic                                   pready
);
   import tba_pkg::*;

   logic [NUM_AXES-1:0][3*COEFF_WIDTH-1:0] row_coeffs;
   logic [NUM_AXES-1:0][COORD_WIDTH-1:0]   offsets;
   pt_ctl_type                             pt_ctl;
   logic [NUM_AXES-1:0][COORD_WIDTH-1:0]   pt_coord;
   logic                                   pt_ready;

   tba_csr #(
      .COORD_WIDTH (COORD_WIDTH),
      .COEFF_WIDTH (COEFF_WIDTH),
      .CSR_DW      (CSR_DW),
      .ADDR_LSB    (ADDR_LSB)
   ) u_csr (
      .clock      (clock),
      .reset      (reset),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready),
      .row_coeffs (row_coeffs),
      .offsets    (offsets)
   );

   tba_xform #(
      .COORD_WIDTH (COORD_WIDTH),
      .COEFF_WIDTH (COEFF_WIDTH)
   ) u_xform (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .row_coeffs (row_coeffs),
      .offsets    (offsets),
      .pt_ctl     (pt_ctl),
      .pt_coord   (pt_coord),
      .pt_ready   (pt_ready)
   );

   tba_bounds #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_bounds (
      .clock    (clock),
      .reset    (reset),
      .pt_ctl   (pt_ctl),
      .pt_coord (pt_coord),
      .pt_ready (pt_ready),
      .rsp_bus  (rsp_bus)
   );

endmodule

// ===== rtl/tba_checker.sv =====
// ----------------------------------------------------------------------------
// tba_checker
// Port-level checks: results never outrun accepted vertices, occupancy
// stays within the pipeline depth, bounds stay ordered, stalled results hold.
// ----------------------------------------------------------------------------
module tba_checker #(
   parameter int COORD_WIDTH = 32
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [COORD_WIDTH-1:0] low_x,
   input logic [COORD_WIDTH-1:0] low_y,
   input logic [COORD_WIDTH-1:0] low_z,
   input logic [COORD_WIDTH-1:0] high_x,
   input logic [COORD_WIDTH-1:0] high_y,
   input logic [COORD_WIDTH-1:0] high_z
);
   // Four transform stages plus the result register
   localparam logic [2:0] MAX_INFLIGHT = 3'd5;

   logic [2:0] inflight_ff, inflight_in;
   logic       req_take, rsp_take;

   assign req_take = req_valid && req_ready;
   assign rsp_take = rsp_valid && rsp_ready;

   // Items accepted but not yet delivered
   always_comb begin
      inflight_in = inflight_ff;
      if (req_take && !rsp_take) begin
         inflight_in = inflight_ff + 3'd1;
      end else if (rsp_take && !req_take) begin
         inflight_in = inflight_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff <= '0;
      end else begin
         inflight_ff <= inflight_in;
      end
   end

   a_no_orphan_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (inflight_ff != 3'd0))
      else $error("result offered with no vertex in flight");

   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      inflight_ff <= MAX_INFLIGHT)
      else $error("more items in flight than pipeline places");

   a_bounds_ordered: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (($signed(low_x) <= $signed(high_x)) &&
                     ($signed(low_y) <= $signed(high_y)) &&
                     ($signed(low_z) <= $signed(high_z))))
      else $error("minimum above maximum on a delivered result");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(low_x) && $stable(low_y) &&
         $stable(low_z) && $stable(high_x) && $stable(high_y) && $stable(high_z)))
      else $error("stalled result changed");

endmodule

bind transformed_bounds_accumulator tba_checker #(
   .COORD_WIDTH (COORD_WIDTH)
) u_tba_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_bus.valid),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .low_x     (rsp_bus.low_x),
   .low_y     (rsp_bus.low_y),
   .low_z     (rsp_bus.low_z),
   .high_x    (rsp_bus.high_x),
   .high_y    (rsp_bus.high_y),
   .high_z    (rsp_bus.high_z)
);
